// ===== hdl/tpfm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tpfm_pkg;

    localparam int ROW_PIXELS = 8;
    localparam int IDX_W      = $clog2(ROW_PIXELS);
    localparam int CNT_W      = $clog2(ROW_PIXELS + 1);

    localparam int COLOR_W   = 2;
    localparam int PALETTE_W = 3;
    localparam int ORDER_W   = 6;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_MODE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BG_ENABLE       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SP_ENABLE       = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SP_MASTER_PRIO  = 2'd3;

    typedef enum logic [1:0] {
        FUNC_BG_PUSH = 2'd0,
        FUNC_SP_PUSH = 2'd1,
        FUNC_EMIT    = 2'd2,
        FUNC_DISCARD = 2'd3
    } func_t;

    typedef struct packed {
        logic [COLOR_W-1:0]   color;
        logic [PALETTE_W-1:0] palette;
        logic                 prio;
    } bg_pix_t;

    typedef struct packed {
        logic [COLOR_W-1:0]   color;
        logic [PALETTE_W-1:0] palette;
        logic [ORDER_W-1:0]   order;
        logic                 prio;
    } sp_pix_t;

    typedef struct packed {
        logic [COLOR_W-1:0]   color;
        logic [PALETTE_W-1:0] palette;
        logic [ORDER_W-1:0]   order;
        logic                 prio;
        logic                 from_sprite;
    } res_pix_t;

    typedef struct packed {
        logic load_bg;
        logic merge_sp;
        logic pop_bg;
        logic pop_sp;
        logic emit;
        logic capture;
        logic accepted;
        logic underflow;
    } cmd_t;

    typedef struct packed {
        logic bg_empty;
        logic sp_empty;
    } sts_t;

endpackage

`default_nettype wire

// ===== hdl/tile_pixel_fifo_mixer.sv =====
// Background and sprite pixel queues (eight pixels each) with a layer mixer.
// For every item, the queues update at the edge that accepts it,
// and its single result sits in the output register from the next cycle on.
// One item per cycle is sustained while results are taken as they appear; the
// one-entry output register is the only limit, so a stalled output holds the
// input back. Configuration writes take effect at once and are meant for idle
// periods.
`timescale 1ns / 1ps
`default_nettype none

module tile_pixel_fifo_mixer (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [1:0]                           func,
    input  wire logic [7:0]                           plane_low,
    input  wire logic [7:0]                           plane_high,
    input  wire logic                                 mirror_row,
    input  wire logic [tpfm_pkg::PALETTE_W-1:0]       row_palette,
    input  wire logic                                 row_priority,
    input  wire logic [tpfm_pkg::ORDER_W-1:0]         row_sprite_order,
    input  wire logic [tpfm_pkg::IDX_W-1:0]           skip_count,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [tpfm_pkg::COLOR_W-1:0]              pixel_color,
    output logic [tpfm_pkg::PALETTE_W-1:0]            pixel_palette,
    output logic [tpfm_pkg::ORDER_W-1:0]              pixel_sprite_order,
    output logic                                      pixel_priority,
    output logic                                      pixel_from_sprite,
    output logic                                      accepted,
    output logic                                      underflow,
    input  wire logic                                 cfg_write_en,
    input  wire logic [tpfm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [tpfm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    tpfm_pkg::cmd_t cmd;
    tpfm_pkg::sts_t sts;

    tpfm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tpfm_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .plane_low          (plane_low),
        .plane_high         (plane_high),
        .mirror_row         (mirror_row),
        .row_palette        (row_palette),
        .row_priority       (row_priority),
        .row_sprite_order   (row_sprite_order),
        .skip_count         (skip_count),
        .cfg_write_en       (cfg_write_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .pixel_color        (pixel_color),
        .pixel_palette      (pixel_palette),
        .pixel_sprite_order (pixel_sprite_order),
        .pixel_priority     (pixel_priority),
        .pixel_from_sprite  (pixel_from_sprite),
        .accepted           (accepted),
        .underflow          (underflow)
    );

endmodule

`default_nettype wire

// ===== hdl/tpfm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tpfm_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    func,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire tpfm_pkg::sts_t sts,
    output tpfm_pkg::cmd_t     cmd
);

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   take;
    tpfm_pkg::func_t op;

    assign op       = tpfm_pkg::func_t'(func);
    assign in_ready = (state_reg == ST_EMPTY) || out_ready;
    assign take     = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.capture  = take;
        cmd.accepted = 1'b1;
        if (take)
        begin
            case (op)
                tpfm_pkg::FUNC_BG_PUSH:
                begin
                    cmd.load_bg  = sts.bg_empty;
                    cmd.accepted = sts.bg_empty;
                end
                tpfm_pkg::FUNC_SP_PUSH:
                begin
                    cmd.merge_sp = 1'b1;
                end
                tpfm_pkg::FUNC_EMIT:
                begin
                    cmd.underflow = sts.bg_empty;
                    cmd.pop_bg    = !sts.bg_empty;
                    cmd.pop_sp    = !sts.bg_empty && !sts.sp_empty;
                    cmd.emit      = !sts.bg_empty;
                end
                tpfm_pkg::FUNC_DISCARD:
                begin
                    cmd.underflow = sts.bg_empty;
                    cmd.pop_bg    = !sts.bg_empty;
                end
                default:
                begin
                    cmd.accepted = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_EMPTY:
            begin
                if (take)
                begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL:
            begin
                if (take)
                begin
                    state_next = ST_FULL;
                end
                else if (out_ready)
                begin
                    state_next = ST_EMPTY;
                end
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
        out_valid_next = (state_next == ST_FULL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_EMPTY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_bg |-> !sts.bg_empty)
        else $error("background pop issued on empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> out_valid)
        else $error("captured result not presented");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_bg || cmd.merge_sp || cmd.pop_bg) |-> cmd.capture)
        else $error("queue command without an accepted item");

endmodule

`default_nettype wire

// ===== hdl/tpfm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tpfm_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire tpfm_pkg::cmd_t                       cmd,
    output tpfm_pkg::sts_t                            sts,
    input  wire logic [7:0]                           plane_low,
    input  wire logic [7:0]                           plane_high,
    input  wire logic                                 mirror_row,
    input  wire logic [tpfm_pkg::PALETTE_W-1:0]       row_palette,
    input  wire logic                                 row_priority,
    input  wire logic [tpfm_pkg::ORDER_W-1:0]         row_sprite_order,
    input  wire logic [tpfm_pkg::IDX_W-1:0]           skip_count,
    input  wire logic                                 cfg_write_en,
    input  wire logic [tpfm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [tpfm_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [tpfm_pkg::COLOR_W-1:0]              pixel_color,
    output logic [tpfm_pkg::PALETTE_W-1:0]            pixel_palette,
    output logic [tpfm_pkg::ORDER_W-1:0]              pixel_sprite_order,
    output logic                                      pixel_priority,
    output logic                                      pixel_from_sprite,
    output logic                                      accepted,
    output logic                                      underflow
);

    localparam int N     = tpfm_pkg::ROW_PIXELS;
    localparam int IDX_W = tpfm_pkg::IDX_W;
    localparam int CNT_W = tpfm_pkg::CNT_W;

    logic color_mode_reg;
    logic bg_enable_reg;
    logic sp_enable_reg;
    logic sp_master_prio_reg;

    tpfm_pkg::bg_pix_t bg_q_reg  [N];
    tpfm_pkg::bg_pix_t bg_q_next [N];
    tpfm_pkg::sp_pix_t sp_q_reg  [N];
    tpfm_pkg::sp_pix_t sp_q_next [N];
    logic [CNT_W-1:0]  bg_count_reg;
    logic [CNT_W-1:0]  bg_count_next;
    logic [CNT_W-1:0]  sp_count_reg;
    logic [CNT_W-1:0]  sp_count_next;

    logic [tpfm_pkg::COLOR_W-1:0] row_color [N];
    logic [CNT_W-1:0]             skip_ext;
    logic [CNT_W-1:0]             start;
    logic [CNT_W-1:0]             offset;

    tpfm_pkg::bg_pix_t  bg_head;
    tpfm_pkg::sp_pix_t  sp_head;
    tpfm_pkg::res_pix_t bg_res;
    tpfm_pkg::res_pix_t sp_res;
    tpfm_pkg::res_pix_t mix_res;
    tpfm_pkg::res_pix_t res_reg;
    tpfm_pkg::res_pix_t res_next;
    logic               accepted_reg;
    logic               underflow_reg;

    assign sts.bg_empty = (bg_count_reg == '0);
    assign sts.sp_empty = (sp_count_reg == '0);

    // unpack one tile row, leftmost pixel first
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            if (mirror_row)
            begin
                row_color[i] = {plane_high[i], plane_low[i]};
            end
            else
            begin
                row_color[i] = {plane_high[N-1-i], plane_low[N-1-i]};
            end
        end
    end

    assign skip_ext = CNT_W'(skip_count);
    assign start    = (skip_ext > sp_count_reg) ? skip_ext : sp_count_reg;
    assign offset   = start - sp_count_reg;

    always_comb
    begin
        logic [CNT_W-1:0]  k;
        tpfm_pkg::sp_pix_t p;
        bg_q_next     = bg_q_reg;
        sp_q_next     = sp_q_reg;
        bg_count_next = bg_count_reg;
        sp_count_next = sp_count_reg;
        k             = '0;
        p             = '0;

        if (cmd.load_bg)
        begin
            for (int j = 0; j < N; j++)
            begin
                bg_q_next[j].color   = row_color[j];
                bg_q_next[j].palette = row_palette;
                bg_q_next[j].prio    = row_priority;
            end
            bg_count_next = CNT_W'(N);
        end
        else if (cmd.pop_bg)
        begin
            for (int j = 0; j < N - 1; j++)
            begin
                bg_q_next[j] = bg_q_reg[j+1];
            end
            bg_count_next = bg_count_reg - CNT_W'(1);
        end

        if (cmd.merge_sp)
        begin
            for (int j = 0; j < N; j++)
            begin
                p.palette = row_palette;
                p.order   = row_sprite_order;
                p.prio    = row_priority;
                if (CNT_W'(j) < sp_count_reg)
                begin
                    // merge into an occupied slot
                    p.color = row_color[j];
                    if (CNT_W'(j) >= skip_ext && p.color != '0 &&
                        (sp_q_reg[j].color == '0 ||
                         (color_mode_reg && p.order < sp_q_reg[j].order)))
                    begin
                        sp_q_next[j] = p;
                    end
                end
                else
                begin
                    // append past the tail
                    k = CNT_W'(j) + offset;
                    p.color = row_color[k[IDX_W-1:0]];
                    if (k < CNT_W'(N))
                    begin
                        sp_q_next[j] = p;
                    end
                end
            end
            sp_count_next = sp_count_reg + (CNT_W'(N) - start);
        end
        else if (cmd.pop_sp)
        begin
            for (int j = 0; j < N - 1; j++)
            begin
                sp_q_next[j] = sp_q_reg[j+1];
            end
            sp_count_next = sp_count_reg - CNT_W'(1);
        end
    end

    // mix the two queue heads
    assign bg_head = bg_q_reg[0];
    assign sp_head = sts.sp_empty ? '0 : sp_q_reg[0];

    always_comb
    begin
        logic bg_on;
        logic sp_on;
        bg_res.color       = bg_head.color;
        bg_res.palette     = bg_head.palette;
        bg_res.order       = '0;
        bg_res.prio        = bg_head.prio;
        bg_res.from_sprite = 1'b0;
        sp_res.color       = sp_head.color;
        sp_res.palette     = sp_head.palette;
        sp_res.order       = sp_head.order;
        sp_res.prio        = sp_head.prio;
        sp_res.from_sprite = 1'b1;
        bg_on = color_mode_reg || bg_enable_reg;
        sp_on = sp_enable_reg;
        mix_res = '0;
        if (bg_on && !sp_on)
        begin
            mix_res = bg_res;
        end
        else if (!bg_on && sp_on)
        begin
            mix_res = (sp_head.color == '0) ? '0 : sp_res;
        end
        else if (!bg_on && !sp_on)
        begin
            mix_res = '0;
        end
        else if (bg_head.color == '0 && sp_head.color != '0)
        begin
            mix_res = sp_res;
        end
        else if (sp_head.color == '0)
        begin
            mix_res = bg_res;
        end
        else if (color_mode_reg)
        begin
            if (sp_master_prio_reg || (!bg_head.prio && !sp_head.prio))
            begin
                mix_res = sp_res;
            end
            else
            begin
                mix_res = bg_res;
            end
        end
        else
        begin
            mix_res = sp_head.prio ? bg_res : sp_res;
        end
    end

    assign res_next = cmd.emit ? mix_res : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg     <= 1'b0;
            bg_enable_reg      <= 1'b1;
            sp_enable_reg      <= 1'b0;
            sp_master_prio_reg <= 1'b1;
            bg_count_reg       <= '0;
            sp_count_reg       <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    tpfm_pkg::CFG_COLOR_MODE:     color_mode_reg     <= cfg_data[0];
                    tpfm_pkg::CFG_BG_ENABLE:      bg_enable_reg      <= cfg_data[0];
                    tpfm_pkg::CFG_SP_ENABLE:      sp_enable_reg      <= cfg_data[0];
                    tpfm_pkg::CFG_SP_MASTER_PRIO: sp_master_prio_reg <= cfg_data[0];
                    default:                      color_mode_reg     <= color_mode_reg;
                endcase
            end
            bg_count_reg <= bg_count_next;
            sp_count_reg <= sp_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bg_q_reg <= bg_q_next;
        sp_q_reg <= sp_q_next;
        if (cmd.capture)
        begin
            res_reg       <= res_next;
            accepted_reg  <= cmd.accepted;
            underflow_reg <= cmd.underflow;
        end
    end

    assign pixel_color        = res_reg.color;
    assign pixel_palette      = res_reg.palette;
    assign pixel_sprite_order = res_reg.order;
    assign pixel_priority     = res_reg.prio;
    assign pixel_from_sprite  = res_reg.from_sprite;
    assign accepted           = accepted_reg;
    assign underflow          = underflow_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (bg_count_reg <= CNT_W'(N)) && (sp_count_reg <= CNT_W'(N)))
        else $error("queue count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_bg |=> (bg_count_reg == CNT_W'(N)))
        else $error("background load did not fill the queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_sp |=> (sp_count_reg == $past(sp_count_reg) - CNT_W'(1)))
        else $error("sprite pop did not advance the queue");

endmodule

`default_nettype wire

// ===== verif/tpfm_checker.sv =====
`timescale 1ns / 1ps

module tpfm_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic                             in_ready,
    input  wire logic [1:0]                       func,
    input  wire logic [7:0]                       plane_low,
    input  wire logic [7:0]                       plane_high,
    input  wire logic                             mirror_row,
    input  wire logic [tpfm_pkg::PALETTE_W-1:0]   row_palette,
    input  wire logic                             row_priority,
    input  wire logic [tpfm_pkg::ORDER_W-1:0]     row_sprite_order,
    input  wire logic [tpfm_pkg::IDX_W-1:0]       skip_count,
    input  wire logic                             out_valid,
    input  wire logic                             out_ready,
    input  wire logic [tpfm_pkg::COLOR_W-1:0]     pixel_color,
    input  wire logic [tpfm_pkg::PALETTE_W-1:0]   pixel_palette,
    input  wire logic [tpfm_pkg::ORDER_W-1:0]     pixel_sprite_order,
    input  wire logic                             pixel_priority,
    input  wire logic                             pixel_from_sprite,
    input  wire logic                             accepted,
    input  wire logic                             underflow,
    input  wire logic                             cfg_write_en,
    input  wire logic [tpfm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tpfm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                    mismatches,
    output int                                    waiting
);
    localparam int ROW_PIXELS = tpfm_pkg::ROW_PIXELS;
    localparam int COLOR_W    = tpfm_pkg::COLOR_W;
    localparam int PALETTE_W  = tpfm_pkg::PALETTE_W;
    localparam int ORDER_W    = tpfm_pkg::ORDER_W;

    typedef struct packed {
        logic [COLOR_W-1:0]   color;
        logic [PALETTE_W-1:0] pal;
        logic [ORDER_W-1:0]   order;
        logic                 prio;
        logic                 sprite;
    } pixel_t;

    typedef struct packed {
        pixel_t px;
        logic   acc;
        logic   unf;
    } outcome_t;

    pixel_t   bg_fifo [ROW_PIXELS];
    pixel_t   sp_fifo [ROW_PIXELS];
    int       bg_fill;
    int       sp_fill;
    logic     color_mode;
    logic     bg_enable;
    logic     sp_enable;
    logic     sp_master;
    outcome_t pixel_q [$];

    function automatic logic [1:0] row_pixel(logic [7:0] lo, logic [7:0] hi, logic mir, int i);
        int b;
        b = mir ? i : ROW_PIXELS - 1 - i;
        return {hi[b], lo[b]};
    endfunction

    task automatic check_field(string what, int want_v, int got_v);
        if (want_v != got_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %0d got %0d", $realtime, what, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : predict
        pixel_t   bg_px;
        pixel_t   sp_px;
        pixel_t   cand;
        pixel_t   mixed;
        outcome_t got;
        outcome_t want;
        logic     bg_on;
        if (!rst_n)
        begin
            bg_fill    = 0;
            sp_fill    = 0;
            color_mode = 1'b0;
            bg_enable  = 1'b1;
            sp_enable  = 1'b0;
            sp_master  = 1'b1;
            mismatches = 0;
            pixel_q.delete();
            waiting   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {pixel_color, pixel_palette, pixel_sprite_order, pixel_priority,
                       pixel_from_sprite, accepted, underflow};
                if (pixel_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no item pending", $realtime);
                end
                else
                begin
                    want = pixel_q[0];
                    pixel_q.delete(0);
                    check_field("pixel_color", want.px.color, got.px.color);
                    check_field("pixel_palette", want.px.pal, got.px.pal);
                    check_field("pixel_sprite_order", want.px.order, got.px.order);
                    check_field("pixel_priority", want.px.prio, got.px.prio);
                    check_field("pixel_from_sprite", want.px.sprite, got.px.sprite);
                    check_field("accepted", want.acc, got.acc);
                    check_field("underflow", want.unf, got.unf);
                end
            end

            if (cfg_write_en)
            begin
                case (cfg_index)
                    tpfm_pkg::CFG_COLOR_MODE:     color_mode = cfg_data[0];
                    tpfm_pkg::CFG_BG_ENABLE:      bg_enable  = cfg_data[0];
                    tpfm_pkg::CFG_SP_ENABLE:      sp_enable  = cfg_data[0];
                    tpfm_pkg::CFG_SP_MASTER_PRIO: sp_master  = cfg_data[0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                want     = '0;
                want.acc = 1'b1;
                case (tpfm_pkg::func_t'(func))
                    tpfm_pkg::FUNC_BG_PUSH:
                    begin
                        if (bg_fill != 0)
                            want.acc = 1'b0;
                        else
                        begin
                            for (int i = 0; i < ROW_PIXELS; i++)
                                bg_fifo[i] = {row_pixel(plane_low, plane_high, mirror_row, i),
                                              row_palette, {ORDER_W{1'b0}}, row_priority, 1'b0};
                            bg_fill = ROW_PIXELS;
                        end
                    end
                    tpfm_pkg::FUNC_SP_PUSH:
                    begin
                        for (int i = 0; i < ROW_PIXELS; i++)
                        begin
                            if (i >= skip_count)
                            begin
                                cand = {row_pixel(plane_low, plane_high, mirror_row, i),
                                        row_palette, row_sprite_order, row_priority, 1'b1};
                                if (sp_fill > i)
                                begin
                                    if (cand.color != 0 && (sp_fifo[i].color == 0 ||
                                        (color_mode && cand.order < sp_fifo[i].order)))
                                        sp_fifo[i] = cand;
                                end
                                else if (sp_fill < ROW_PIXELS)
                                begin
                                    sp_fifo[sp_fill] = cand;
                                    sp_fill++;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        if (bg_fill == 0)
                            want.unf = 1'b1;
                        else
                        begin
                            bg_px = bg_fifo[0];
                            for (int k = 0; k < ROW_PIXELS - 1; k++)
                                bg_fifo[k] = bg_fifo[k + 1];
                            bg_fill--;
                            if (tpfm_pkg::func_t'(func) == tpfm_pkg::FUNC_EMIT)
                            begin
                                sp_px = '0;
                                if (sp_fill != 0)
                                begin
                                    sp_px = sp_fifo[0];
                                    for (int k = 0; k < ROW_PIXELS - 1; k++)
                                        sp_fifo[k] = sp_fifo[k + 1];
                                    sp_fill--;
                                end
                                bg_on = color_mode || bg_enable;
                                if (bg_on && !sp_enable)
                                    mixed = bg_px;
                                else if (!bg_on && sp_enable)
                                    mixed = (sp_px.color == 0) ? pixel_t'('0) : sp_px;
                                else if (!bg_on)
                                    mixed = '0;
                                else if (bg_px.color == 0 && sp_px.color != 0)
                                    mixed = sp_px;
                                else if (sp_px.color == 0)
                                    mixed = bg_px;
                                else if (color_mode)
                                    mixed = (sp_master || (!bg_px.prio && !sp_px.prio)) ?
                                            sp_px : bg_px;
                                else
                                    mixed = sp_px.prio ? bg_px : sp_px;
                                want.px = mixed;
                            end
                        end
                    end
                endcase
                pixel_q = {pixel_q, want};
            end
            waiting <= pixel_q.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    localparam int ROW_PIXELS  = tpfm_pkg::ROW_PIXELS;
    localparam int COLOR_W     = tpfm_pkg::COLOR_W;
    localparam int PALETTE_W   = tpfm_pkg::PALETTE_W;
    localparam int ORDER_W     = tpfm_pkg::ORDER_W;
    localparam int IDX_W       = tpfm_pkg::IDX_W;
    localparam int CFG_INDEX_W = tpfm_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = tpfm_pkg::CFG_DATA_W;

    logic                   clk              = 1'b0;
    logic                   rst_n            = 1'b0;
    logic                   in_valid         = 1'b0;
    logic                   in_ready;
    logic [1:0]             func             = '0;
    logic [7:0]             plane_low        = '0;
    logic [7:0]             plane_high       = '0;
    logic                   mirror_row       = 1'b0;
    logic [PALETTE_W-1:0]   row_palette      = '0;
    logic                   row_priority     = 1'b0;
    logic [ORDER_W-1:0]     row_sprite_order = '0;
    logic [IDX_W-1:0]       skip_count       = '0;
    logic                   out_valid;
    logic                   out_ready        = 1'b0;
    logic [COLOR_W-1:0]     pixel_color;
    logic [PALETTE_W-1:0]   pixel_palette;
    logic [ORDER_W-1:0]     pixel_sprite_order;
    logic                   pixel_priority;
    logic                   pixel_from_sprite;
    logic                   accepted;
    logic                   underflow;
    logic                   cfg_write_en     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index        = '0;
    logic [CFG_DATA_W-1:0]  cfg_data         = '0;

    int   mismatches;
    int   waiting;
    int   items_sent = 0;
    int   phase_no   = -1;
    logic steady     = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    tile_pixel_fifo_mixer dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .func               (func),
        .plane_low          (plane_low),
        .plane_high         (plane_high),
        .mirror_row         (mirror_row),
        .row_palette        (row_palette),
        .row_priority       (row_priority),
        .row_sprite_order   (row_sprite_order),
        .skip_count         (skip_count),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .pixel_color        (pixel_color),
        .pixel_palette      (pixel_palette),
        .pixel_sprite_order (pixel_sprite_order),
        .pixel_priority     (pixel_priority),
        .pixel_from_sprite  (pixel_from_sprite),
        .accepted           (accepted),
        .underflow          (underflow),
        .cfg_write_en       (cfg_write_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    tpfm_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .func               (func),
        .plane_low          (plane_low),
        .plane_high         (plane_high),
        .mirror_row         (mirror_row),
        .row_palette        (row_palette),
        .row_priority       (row_priority),
        .row_sprite_order   (row_sprite_order),
        .skip_count         (skip_count),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .pixel_color        (pixel_color),
        .pixel_palette      (pixel_palette),
        .pixel_sprite_order (pixel_sprite_order),
        .pixel_priority     (pixel_priority),
        .pixel_from_sprite  (pixel_from_sprite),
        .accepted           (accepted),
        .underflow          (underflow),
        .cfg_write_en       (cfg_write_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatches         (mismatches),
        .waiting            (waiting)
    );

    task automatic put(tpfm_pkg::func_t f, logic [7:0] lo, logic [7:0] hi, logic mir,
                       logic [PALETTE_W-1:0] pal, logic pri, logic [ORDER_W-1:0] ord,
                       logic [IDX_W-1:0] skip);
        if (!steady && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid         <= 1'b1;
        func             <= f;
        plane_low        <= lo;
        plane_high       <= hi;
        mirror_row       <= mir;
        row_palette      <= pal;
        row_priority     <= pri;
        row_sprite_order <= ord;
        skip_count       <= skip;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic put_random(tpfm_pkg::func_t f);
        logic [7:0]         lo;
        logic [7:0]         hi;
        logic [ORDER_W-1:0] ord;
        logic [IDX_W-1:0]   skip;
        lo   = 8'($urandom_range(255));
        hi   = 8'($urandom_range(255));
        ord  = ($urandom_range(9) == 0) ? ORDER_W'($urandom_range(63))
                                        : ORDER_W'($urandom_range(39));
        skip = $urandom_range(1) ? IDX_W'(0) : IDX_W'($urandom_range(7));
        put(f, lo, hi, 1'($urandom_range(1)), PALETTE_W'($urandom_range(7)),
            1'($urandom_range(1)), ord, skip);
    endtask

    // hold until every pending item has come out, then let the pipe go quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(logic cm, logic be, logic se, logic smp);
        settle();
        cfg_write_en <= 1'b1;
        cfg_index    <= tpfm_pkg::CFG_COLOR_MODE;
        cfg_data     <= cm;
        @(posedge clk);
        cfg_index    <= tpfm_pkg::CFG_BG_ENABLE;
        cfg_data     <= be;
        @(posedge clk);
        cfg_index    <= tpfm_pkg::CFG_SP_ENABLE;
        cfg_data     <= se;
        @(posedge clk);
        cfg_index    <= tpfm_pkg::CFG_SP_MASTER_PRIO;
        cfg_data     <= smp;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    initial
    begin : receiver
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase_no == 3 && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (60) @(posedge clk);
            end
            else
                out_ready <= steady || ($urandom_range(99) >= 14);
        end
    end

    initial
    begin : stimulus
        int phase_end;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put(tpfm_pkg::FUNC_EMIT, 8'h00, 8'h00, 1'b0, 3'd0, 1'b0, 6'd0, 3'd0);
        put(tpfm_pkg::FUNC_DISCARD, 8'hFF, 8'hFF, 1'b1, 3'd7, 1'b1, 6'd63, 3'd7);
        put(tpfm_pkg::FUNC_BG_PUSH, 8'hFF, 8'h00, 1'b0, 3'd7, 1'b1, 6'd0, 3'd0);
        put(tpfm_pkg::FUNC_BG_PUSH, 8'h00, 8'hFF, 1'b1, 3'd0, 1'b0, 6'd0, 3'd0);
        put(tpfm_pkg::FUNC_SP_PUSH, 8'hAA, 8'h55, 1'b1, 3'd7, 1'b1, 6'd63, 3'd0);
        put(tpfm_pkg::FUNC_EMIT, 8'h00, 8'h00, 1'b0, 3'd0, 1'b0, 6'd0, 3'd0);
        put(tpfm_pkg::FUNC_DISCARD, 8'h00, 8'h00, 1'b0, 3'd0, 1'b0, 6'd0, 3'd0);

        configure(1'b1, 1'b0, 1'b1, 1'b0);
        put(tpfm_pkg::FUNC_SP_PUSH, 8'h0F, 8'hF0, 1'b0, 3'd3, 1'b0, 6'd39, 3'd5);
        put(tpfm_pkg::FUNC_SP_PUSH, 8'hFF, 8'hFF, 1'b0, 3'd5, 1'b1, 6'd2, 3'd0);
        put(tpfm_pkg::FUNC_BG_PUSH, 8'h3C, 8'hC3, 1'b1, 3'd2, 1'b1, 6'd0, 3'd0);
        repeat (9) put(tpfm_pkg::FUNC_EMIT, 8'h00, 8'h00, 1'b0, 3'd0, 1'b0, 6'd0, 3'd0);
        put(tpfm_pkg::FUNC_BG_PUSH, 8'h5A, 8'hA5, 1'b0, 3'd1, 1'b0, 6'd0, 3'd0);
        put(tpfm_pkg::FUNC_EMIT, 8'h00, 8'h00, 1'b0, 3'd0, 1'b0, 6'd0, 3'd0);

        configure(1'b0, 1'b0, 1'b1, 1'b1);
        put(tpfm_pkg::FUNC_BG_PUSH, 8'h00, 8'h00, 1'b0, 3'd4, 1'b0, 6'd0, 3'd0);
        put(tpfm_pkg::FUNC_SP_PUSH, 8'h81, 8'h18, 1'b0, 3'd6, 1'b1, 6'd17, 3'd2);
        repeat (3) put(tpfm_pkg::FUNC_EMIT, 8'h00, 8'h00, 1'b0, 3'd0, 1'b0, 6'd0, 3'd0);

        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0:       configure(1'b0, 1'b0, 1'b0, 1'b0);
                1:       configure(1'b1, 1'b1, 1'b1, 1'b1);
                default: configure(1'($urandom_range(1)), 1'($urandom_range(1)),
                                   1'($urandom_range(1)), 1'($urandom_range(1)));
            endcase
            phase_no  <= ph;
            steady    <= (ph == 5);
            phase_end  = items_sent + 160;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(99) < 15)
                    put_random(tpfm_pkg::func_t'($urandom_range(3)));
                else
                begin
                    // one tile row: load background, then drain it with sprites mixed in
                    put_random(tpfm_pkg::FUNC_BG_PUSH);
                    for (int n = 0; n < ROW_PIXELS; n++)
                    begin
                        if ($urandom_range(99) < 25)
                            put_random(tpfm_pkg::FUNC_SP_PUSH);
                        put_random(($urandom_range(99) < 80) ? tpfm_pkg::FUNC_EMIT
                                                             : tpfm_pkg::FUNC_DISCARD);
                    end
                end
            end
        end

        settle();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : watchdog
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
